>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the running median block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

`endif

>>> design/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Types, widths and helpers for the sliding window median block.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

  localparam int MAX_WINDOW = 32;
  localparam int IDX_W      = $clog2(MAX_WINDOW);
  localparam int CNT_W      = IDX_W + 1;
  localparam int DATA_W     = 32;
  localparam int TIME_W     = 32;
  localparam int CFG_W      = 6;

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef logic        [TIME_W-1:0] time_t;
  typedef logic        [CNT_W-1:0]  cnt_t;
  typedef logic        [IDX_W-1:0]  idx_t;
  typedef logic        [CFG_W-1:0]  cfg_t;

  localparam cfg_t WIN_RESET = cfg_t'(5);

  // Clamp the programmed size into 1..MAX_WINDOW.
  function automatic cnt_t eff_size(input cfg_t cfg);
    logic [31:0] w;
    w = 32'(cfg);
    if (w == 32'd0) begin
      return cnt_t'(1);
    end else if (w > 32'(MAX_WINDOW)) begin
      return cnt_t'(MAX_WINDOW);
    end else begin
      return cnt_t'(w);
    end
  endfunction

endpackage

`default_nettype wire

>>> design/sliding_window_median.sv
// ----------------------------------------------------------------------------
// sliding_window_median
// Running median over the last N signed Q16.16 samples, with the start time
// of the oldest sample in the window.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid/in_ready   | sample_value, start_time
// out     | output    | out_valid/out_ready | median_value, window_start_time
// cfg     | input     | cfg_wr_en (no wait) | window_size
//
// A sorted copy of the window lives in a ping-pong memory. Each transaction
// takes one merge pass through it with a single compare unit: insert the new
// sample, pick off the middle values, drop the oldest sample.
// A new sample is taken only when idle, once the previous transaction is done.
// Reset: synchronous; fill count and oldest index clear, window size is 5.
// A result waiting on out_ready holds the block in its last step only.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_median (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  swm_pkg::sample_t       in_sample_value,
  input  swm_pkg::time_t         in_start_time,
  output logic                   out_valid,
  input  logic                   out_ready,
  output swm_pkg::sample_t       out_median_value,
  output swm_pkg::time_t         out_window_start_time,
  input  logic                   cfg_wr_en,
  input  swm_pkg::cfg_t          cfg_wr_data
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_FETCH  = 2'd1;
  localparam logic [1:0] ST_MERGE  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]       state_r, state_nxt;
  swm_pkg::cfg_t    win_size_r;
  swm_pkg::cnt_t    win_n;
  swm_pkg::cnt_t    fill_r;
  swm_pkg::idx_t    oldest_r;
  logic             bank_r;

  swm_pkg::sample_t x_r;
  swm_pkg::cnt_t    m_r;
  logic             full_r;
  swm_pkg::cnt_t    rd_r, rd_nxt;
  swm_pkg::cnt_t    wr_r;
  swm_pkg::cnt_t    pos_r;
  logic             ins_r;
  logic             del_done_r;
  swm_pkg::sample_t lo_r, hi_r;

  swm_pkg::sample_t val_mem [swm_pkg::MAX_WINDOW];
  swm_pkg::time_t   tim_mem [swm_pkg::MAX_WINDOW];
  swm_pkg::sample_t srt_mem [2*swm_pkg::MAX_WINDOW];
  swm_pkg::sample_t val_rd_r;
  swm_pkg::time_t   tim_rd_r;
  swm_pkg::sample_t srt_rd_r;

  logic             out_valid_r;
  swm_pkg::sample_t out_median_r;
  swm_pkg::time_t   out_time_r;

  logic                   in_acc;
  swm_pkg::idx_t          slot;
  logic [swm_pkg::IDX_W:0] srt_raddr;
  logic                   have_e;
  logic                   take_x;
  swm_pkg::sample_t       y;
  logic                   drop;
  logic                   last;
  logic                   srt_we;
  swm_pkg::cnt_t          k_hi, k_lo;
  logic                   advance;
  logic                   finish_go;
  logic [swm_pkg::DATA_W:0] pair_sum;

  assign win_n    = swm_pkg::eff_size(win_size_r);
  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign slot     = oldest_r + fill_r[swm_pkg::IDX_W-1:0];

  assign k_hi = win_n >> 1;
  assign k_lo = k_hi - swm_pkg::cnt_t'(1);

  // Merge step: emit the smaller of the new sample and the next sorted entry.
  assign have_e = (rd_r < m_r);
  assign take_x = !ins_r && (!have_e || (x_r < srt_rd_r));
  assign y      = take_x ? x_r : srt_rd_r;
  assign drop   = full_r && !del_done_r && (y == val_rd_r);
  assign last   = (pos_r == m_r);
  assign srt_we = (state_r == ST_MERGE) && !drop;

  assign advance   = !full_r || !out_valid_r || out_ready;
  assign finish_go = (state_r == ST_FINISH) && advance;
  assign pair_sum  = {lo_r[swm_pkg::DATA_W-1], lo_r} + {hi_r[swm_pkg::DATA_W-1], hi_r};

  always_comb begin
    rd_nxt = rd_r;
    case (state_r)
      ST_IDLE:  rd_nxt = '0;
      ST_MERGE: if (!take_x) rd_nxt = rd_r + swm_pkg::cnt_t'(1);
      default:  rd_nxt = rd_r;
    endcase
  end

  assign srt_raddr = {bank_r, rd_nxt[swm_pkg::IDX_W-1:0]};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = ST_FETCH;
      ST_FETCH:  state_nxt = ST_MERGE;
      ST_MERGE:  if (last) state_nxt = ST_FINISH;
      ST_FINISH: if (advance) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Circular sample store, read at the oldest slot every cycle.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      val_mem[slot] <= in_sample_value;
      tim_mem[slot] <= in_start_time;
    end
    val_rd_r <= val_mem[oldest_r];
    tim_rd_r <= tim_mem[oldest_r];
  end

  // Sorted window, ping-pong halves: read active bank, write the other.
  always_ff @(posedge clk) begin
    if (srt_we) begin
      srt_mem[{~bank_r, wr_r[swm_pkg::IDX_W-1:0]}] <= y;
    end
    srt_rd_r <= srt_mem[srt_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      win_size_r  <= swm_pkg::WIN_RESET;
      fill_r      <= '0;
      oldest_r    <= '0;
      bank_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // a new result replaces one that leaves at the same edge
      if (finish_go && full_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (finish_go) begin
        bank_r <= ~bank_r;
        if (full_r) begin
          oldest_r <= oldest_r + swm_pkg::idx_t'(1);
        end
      end
      if (cfg_wr_en) begin
        win_size_r <= cfg_wr_data;
        fill_r     <= '0;
      end else if (finish_go) begin
        fill_r <= full_r ? m_r : m_r + swm_pkg::cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= rd_nxt;
    if (in_acc) begin
      x_r        <= in_sample_value;
      m_r        <= fill_r;
      full_r     <= ((fill_r + swm_pkg::cnt_t'(1)) >= win_n);
      wr_r       <= '0;
      pos_r      <= '0;
      ins_r      <= 1'b0;
      del_done_r <= 1'b0;
    end
    if (state_r == ST_MERGE) begin
      if (take_x) ins_r <= 1'b1;
      if (pos_r == k_lo) lo_r <= y;
      if (pos_r == k_hi) hi_r <= y;
      if (drop) begin
        del_done_r <= 1'b1;
      end else begin
        wr_r <= wr_r + swm_pkg::cnt_t'(1);
      end
      pos_r <= pos_r + swm_pkg::cnt_t'(1);
    end
    if (finish_go && full_r) begin
      out_median_r <= win_n[0] ? hi_r : swm_pkg::sample_t'(pair_sum[swm_pkg::DATA_W:1]);
      out_time_r   <= tim_rd_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_median_value      = out_median_r;
  assign out_window_start_time = out_time_r;

endmodule

`default_nettype wire

>>> design/swm_checker.sv
// ----------------------------------------------------------------------------
// swm_checker
// Port-level checks for the sliding window median block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module swm_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input swm_pkg::sample_t in_sample_value,
  input swm_pkg::time_t   in_start_time,
  input logic             out_valid,
  input logic             out_ready,
  input swm_pkg::sample_t out_median_value,
  input swm_pkg::time_t   out_window_start_time,
  input logic             cfg_wr_en,
  input swm_pkg::cfg_t    cfg_wr_data
);

  // Stalled result holds.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_median_value) && $stable(out_window_start_time))

  // Busy right after taking a transaction.
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

  // A new result only appears out of the busy phase.
  `ASSERT_SAME(a_result_from_busy, clk, rst_n, $rose(out_valid), !$past(in_ready))

endmodule

bind sliding_window_median swm_checker u_swm_checker (.*);

`default_nettype wire
